>>> rtl/core/amab_pkg.sv
// ----------------------------------------------------------------------------
// amab_pkg
// Shared constants, types and helpers of the adaptive moving-average binarizer.
// ----------------------------------------------------------------------------
`default_nettype none

package amab_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int FRAC_BITS  = 9;
   localparam int SUM_BITS   = 16;

   localparam int PIX_BITS   = 8;
   localparam int COL_BITS   = $clog2(MAX_WIDTH);
   localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
   localparam int DIM_BITS   = 9;
   localparam int COEF_BITS  = 10;
   localparam int ADDR_BITS  = 5;
   localparam int DATA_BITS  = 32;
   localparam int PROD_BITS  = SUM_BITS + COEF_BITS;
   localparam int SHIFT_BITS = PROD_BITS - FRAC_BITS;

   localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};
   localparam logic [PIX_BITS-1:0] PIX_WHITE = 8'hff;
   localparam logic [PIX_BITS-1:0] PIX_BLACK = 8'h00;

   // register indexes
   localparam logic [2:0] REG_IMAGE_WIDTH      = 3'd0;
   localparam logic [2:0] REG_IMAGE_HEIGHT     = 3'd1;
   localparam logic [2:0] REG_DECAY_MULTIPLIER = 3'd2;
   localparam logic [2:0] REG_THRESHOLD_FACTOR = 3'd3;
   localparam logic [2:0] REG_INITIAL_SUM      = 3'd4;

   localparam logic [DIM_BITS-1:0]  RESET_WIDTH  = 9'd188;
   localparam logic [DIM_BITS-1:0]  RESET_HEIGHT = 9'd120;
   localparam logic [COEF_BITS-1:0] RESET_DECAY  = 10'd490;
   localparam logic [COEF_BITS-1:0] RESET_FACTOR = 10'd18;
   localparam logic [SUM_BITS-1:0]  RESET_INIT   = 16'd2921;

   typedef struct packed {
      logic [DIM_BITS-1:0]  image_width;
      logic [DIM_BITS-1:0]  image_height;
      logic [COEF_BITS-1:0] decay_multiplier;
      logic [COEF_BITS-1:0] threshold_factor;
      logic [SUM_BITS-1:0]  initial_sum;
   } cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SUM,
      ST_THR
   } state_type;

   // zero counts as one, anything above the limit is the limit
   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                      input logic [DIM_BITS-1:0] hi);
      logic [DIM_BITS-1:0] r;
      if (v == '0) begin
         r = DIM_BITS'(1);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/adaptive_moving_average_binarizer.sv
// ----------------------------------------------------------------------------
// adaptive_moving_average_binarizer
// Adaptive-threshold binarizer for a serpentine gray pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one gray pixel per request (valid/ready), in serpentine
//   order; req_frame_start forces a new frame at that pixel. rsp_* returns
//   one binary pixel (0 or 255) per request with its column and an end of
//   frame flag. The APB port (psel..pready, pready always high) holds the
//   geometry, decay, threshold factor and initial sum; write it while idle.
//   A request accepted in idle goes through the sum step and the threshold
//   step, then into the output register. One pixel is worked on at a time,
//   held back by the read-modify-write of the line store and the two chained
//   multiplies (decay, then threshold), each followed by a register.
//   The next request is taken while a finished result waits on a stalled
//   receiver; a third one waits until the output register frees.
//   Reset restores the register defaults and starts at row 0 column 0.
//   The line store needs no clearing pass: the first row of every frame
//   uses the initial sum instead of the stored value.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_moving_average_binarizer (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [amab_pkg::PIX_BITS-1:0]   req_pixel_value,
   input  wire logic                            req_frame_start,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [amab_pkg::PIX_BITS-1:0]   rsp_binary_pixel,
   output logic      [amab_pkg::COL_BITS-1:0]   rsp_column_index,
   output logic                                 rsp_frame_last,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [amab_pkg::ADDR_BITS-1:0]  paddr,
   input  wire logic [amab_pkg::DATA_BITS-1:0]  pwdata,
   output logic      [amab_pkg::DATA_BITS-1:0]  prdata,
   output logic                                 pready
);

   import amab_pkg::*;

   cfg_type cfg;

   state_type state_ff, state_in;

   // scan position and running sum
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [COL_BITS-1:0]   col_ff, col_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic                  rev_ff, rev_in;

   // per-request working registers
   logic [PIX_BITS-1:0]   pix_ff;
   logic [PROD_BITS-1:0]  prod_ff;
   logic [COL_BITS-1:0]   wcol_ff;
   logic                  first_row_ff;
   logic                  last_ff;
   logic [SUM_BITS-1:0]   avg_ff, avg_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [PIX_BITS-1:0]   rsp_pix_ff;
   logic [COL_BITS-1:0]   rsp_col_ff;
   logic                  rsp_last_ff;

   logic                  accept;
   logic                  load_out;
   logic [SUM_BITS-1:0]   sum_eff;
   logic [COL_BITS-1:0]   col_eff;
   logic [ROW_BITS-1:0]   row_eff;
   logic                  rev_eff;
   logic [DIM_BITS-1:0]   w_eff, h_eff;
   logic                  row_end, frame_end;
   logic [PROD_BITS-1:0]  prod_in;

   logic [SHIFT_BITS:0]   sum_full;
   logic [SUM_BITS-1:0]   sum_new;
   logic [SUM_BITS-1:0]   prev_sum;
   logic [SUM_BITS:0]     pair_sum;
   logic [PROD_BITS-1:0]  thr_prod;
   logic [SHIFT_BITS-1:0] thr;
   logic                  dark;

   logic                  ram_wr_en;
   logic [SUM_BITS-1:0]   ram_rd_data;

   amab_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   amab_ram #(
      .WIDTH (SUM_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wcol_ff),
      .wr_data (sum_new),
      .rd_en   (accept),
      .rd_addr (col_eff),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;

   // position as seen by this pixel, frame start overriding
   always_comb begin
      w_eff = clamp_dim(cfg.image_width, DIM_BITS'(MAX_WIDTH));
      h_eff = clamp_dim(cfg.image_height, DIM_BITS'(MAX_HEIGHT));
      if (req_frame_start) begin
         sum_eff = cfg.initial_sum;
         col_eff = '0;
         row_eff = '0;
         rev_eff = 1'b0;
      end else begin
         sum_eff = sum_ff;
         col_eff = col_ff;
         row_eff = row_ff;
         rev_eff = rev_ff;
      end
      if (rev_eff) begin
         row_end = (col_eff == '0);
      end else begin
         row_end = (({1'b0, col_eff} + DIM_BITS'(1)) >= w_eff);
      end
      frame_end = row_end && (({1'b0, row_eff} + DIM_BITS'(1)) >= h_eff);
      prod_in   = PROD_BITS'(sum_eff) * PROD_BITS'(cfg.decay_multiplier);
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      rev_in = rev_ff;
      if (accept) begin
         priority if (frame_end) begin
            col_in = '0;
            row_in = '0;
            rev_in = 1'b0;
         end else if (row_end) begin
            row_in = row_eff + ROW_BITS'(1);
            rev_in = ~rev_eff;
            col_in = rev_eff ? COL_BITS'(0) : COL_BITS'(w_eff - DIM_BITS'(1));
         end else begin
            row_in = row_eff;
            rev_in = rev_eff;
            col_in = rev_eff ? (col_eff - COL_BITS'(1)) : (col_eff + COL_BITS'(1));
         end
      end
   end

   // decayed sum, line store update and average
   always_comb begin
      sum_full = {1'b0, prod_ff[PROD_BITS-1:FRAC_BITS]} + (SHIFT_BITS+1)'(pix_ff);
      if (sum_full > (SHIFT_BITS+1)'(SUM_MAX)) begin
         sum_new = SUM_MAX;
      end else begin
         sum_new = sum_full[SUM_BITS-1:0];
      end
      prev_sum  = first_row_ff ? cfg.initial_sum : ram_rd_data;
      pair_sum  = {1'b0, sum_new} + {1'b0, prev_sum};
      avg_in    = pair_sum[SUM_BITS:1];
      ram_wr_en = (state_ff == ST_SUM);
      sum_in    = sum_ff;
      if (state_ff == ST_SUM) begin
         // a finished frame restarts from the initial sum
         sum_in = last_ff ? cfg.initial_sum : sum_new;
      end
   end

   // threshold compare
   always_comb begin
      thr_prod = PROD_BITS'(avg_ff) * PROD_BITS'(cfg.threshold_factor);
      thr      = thr_prod[PROD_BITS-1:FRAC_BITS];
      dark     = (SHIFT_BITS'(pix_ff) < thr);
   end

   always_comb begin
      state_in     = state_ff;
      load_out     = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            state_in = ST_THR;
         end
         ST_THR: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= RESET_INIT;
         col_ff       <= '0;
         row_ff       <= '0;
         rev_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         rev_ff       <= rev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff       <= req_pixel_value;
         prod_ff      <= prod_in;
         wcol_ff      <= col_eff;
         first_row_ff <= (row_eff == '0);
         last_ff      <= frame_end;
      end
      if (state_ff == ST_SUM) begin
         avg_ff <= avg_in;
      end
      if (load_out) begin
         rsp_pix_ff  <= dark ? PIX_BLACK : PIX_WHITE;
         rsp_col_ff  <= wcol_ff;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_binary_pixel = rsp_pix_ff;
   assign rsp_column_index = rsp_col_ff;
   assign rsp_frame_last   = rsp_last_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SUM))
      else $error("accepted request did not enter the sum step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_THR) && rsp_valid_ff && !rsp_ready |=> (state_ff == ST_THR))
      else $error("result dropped while output stalled");

   a_binary_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_pix_ff == PIX_BLACK) || (rsp_pix_ff == PIX_WHITE))
      else $error("output pixel is not binary");

endmodule

`default_nettype wire

>>> rtl/core/amab_ram.sv
// ----------------------------------------------------------------------------
// amab_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module amab_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/amab_csr.sv
// ----------------------------------------------------------------------------
// amab_csr
// APB register file holding geometry, decay, threshold factor and initial sum.
// ----------------------------------------------------------------------------
`default_nettype none

module amab_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [amab_pkg::ADDR_BITS-1:0]     paddr,
   input  wire logic [amab_pkg::DATA_BITS-1:0]     pwdata,
   output logic      [amab_pkg::DATA_BITS-1:0]     prdata,
   output logic                                    pready,
   output amab_pkg::cfg_type                       cfg
);

   import amab_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_index;
   logic       wr_stb;

   assign reg_index = paddr[ADDR_BITS-1:2];
   assign pready    = 1'b1;
   assign wr_stb    = psel & penable & pwrite & pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_stb) begin
         unique case (reg_index)
            REG_IMAGE_WIDTH:      cfg_in.image_width      = pwdata[DIM_BITS-1:0];
            REG_IMAGE_HEIGHT:     cfg_in.image_height     = pwdata[DIM_BITS-1:0];
            REG_DECAY_MULTIPLIER: cfg_in.decay_multiplier = pwdata[COEF_BITS-1:0];
            REG_THRESHOLD_FACTOR: cfg_in.threshold_factor = pwdata[COEF_BITS-1:0];
            REG_INITIAL_SUM:      cfg_in.initial_sum      = pwdata[SUM_BITS-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_IMAGE_WIDTH:      prdata = DATA_BITS'(cfg_ff.image_width);
         REG_IMAGE_HEIGHT:     prdata = DATA_BITS'(cfg_ff.image_height);
         REG_DECAY_MULTIPLIER: prdata = DATA_BITS'(cfg_ff.decay_multiplier);
         REG_THRESHOLD_FACTOR: prdata = DATA_BITS'(cfg_ff.threshold_factor);
         REG_INITIAL_SUM:      prdata = DATA_BITS'(cfg_ff.initial_sum);
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width      <= RESET_WIDTH;
         cfg_ff.image_height     <= RESET_HEIGHT;
         cfg_ff.decay_multiplier <= RESET_DECAY;
         cfg_ff.threshold_factor <= RESET_FACTOR;
         cfg_ff.initial_sum      <= RESET_INIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> tb/tb_adaptive_moving_average_binarizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_moving_average_binarizer
// Self-checking bench for the adaptive moving-average binarizer.
// A queue-fed driver sends gray pixels over the valid/ready request port while
// an in-bench model tracks the decayed sum, the line of previous-row sums and
// the serpentine scan position. The monitor compares every response with the
// model's prediction. Settings are rewritten over APB between phases and read
// back; traffic runs with no idling, a slow sender, a slow receiver and both.
// ----------------------------------------------------------------------------

module tb_adaptive_moving_average_binarizer;
   import amab_pkg::*;

   typedef struct packed {
      logic [PIX_BITS-1:0] pixel;
      logic                frame_start;
   } pixel_req_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] binary_pixel;
      logic [COL_BITS-1:0] column_index;
      logic                frame_last;
   } bin_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [PIX_BITS-1:0]  req_pixel_value = '0;
   logic                 req_frame_start = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [PIX_BITS-1:0]  rsp_binary_pixel;
   logic [COL_BITS-1:0]  rsp_column_index;
   logic                 rsp_frame_last;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [ADDR_BITS-1:0] paddr = '0;
   logic [DATA_BITS-1:0] pwdata = '0;
   logic [DATA_BITS-1:0] prdata;
   logic                 pready;

   pixel_req_type  pending_pixels[$];
   bin_result_type predicted_pixels[$];

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  mismatch_count = 0;
   int  pixels_accepted = 0;
   int  results_checked = 0;
   int  frames_closed = 0;
   int  settings_applied = 0;
   logic req_taken = 1'b0;

   // model state: register copy, decayed sum, previous-row line, scan position
   cfg_type             cfg_shadow;
   logic [SUM_BITS-1:0] sum_state;
   logic [SUM_BITS-1:0] line_store [MAX_WIDTH];
   logic [COL_BITS-1:0] col_pos;
   logic [7:0]          row_pos;
   logic                reverse_dir;

   adaptive_moving_average_binarizer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_value  (req_pixel_value),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_binary_pixel (rsp_binary_pixel),
      .rsp_column_index (rsp_column_index),
      .rsp_frame_last   (rsp_frame_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #(8_000_000);
      $display("Mismatches found");
      $finish;
   end

   // zero acts as one, anything past the limit is the limit
   function automatic logic [DIM_BITS-1:0] dim_limit(input logic [DIM_BITS-1:0] v,
                                                     input int hi);
      logic [DIM_BITS-1:0] r;
      if (v == '0) begin
         r = DIM_BITS'(1);
      end else if (v > hi) begin
         r = hi[DIM_BITS-1:0];
      end else begin
         r = v;
      end
      return r;
   endfunction

   task automatic restart_scan();
      sum_state   = cfg_shadow.initial_sum;
      col_pos     = '0;
      row_pos     = '0;
      reverse_dir = 1'b0;
   endtask

   task automatic binarize_pixel(input logic [PIX_BITS-1:0] pixel, input logic fs,
                                 output bin_result_type r);
      logic [DIM_BITS-1:0]            w;
      logic [DIM_BITS-1:0]            h;
      logic [COL_BITS-1:0]            col;
      logic [PROD_BITS-1:0]           decay_prod;
      logic [SUM_BITS+1:0]            s_full;
      logic [SUM_BITS-1:0]            s;
      logic [SUM_BITS-1:0]            prev;
      logic [SUM_BITS:0]              pair;
      logic [SUM_BITS-1:0]            avg;
      logic [PROD_BITS-1:0]           thr_prod;
      logic [SUM_BITS:0]              thr;
      logic                           row_end;
      logic                           frame_end;
      w = dim_limit(cfg_shadow.image_width, MAX_WIDTH);
      h = dim_limit(cfg_shadow.image_height, MAX_HEIGHT);
      if (fs) begin
         restart_scan();
      end
      col = col_pos;
      decay_prod = sum_state * cfg_shadow.decay_multiplier;
      s_full = (SUM_BITS+2)'((decay_prod >> FRAC_BITS) + pixel);
      s = (s_full > SUM_MAX) ? SUM_MAX : s_full[SUM_BITS-1:0];
      sum_state = s;
      prev = (row_pos == 0) ? cfg_shadow.initial_sum : line_store[col];
      line_store[col] = s;
      pair = s + prev;
      avg = pair[SUM_BITS:1];
      thr_prod = avg * cfg_shadow.threshold_factor;
      thr = thr_prod[PROD_BITS-1:FRAC_BITS];
      r.binary_pixel = (pixel < thr) ? PIX_BLACK : PIX_WHITE;
      r.column_index = col;
      row_end = reverse_dir ? (col == 0) : ({1'b0, col} + 9'd1 >= w);
      frame_end = row_end && ({1'b0, row_pos} + 9'd1 >= h);
      r.frame_last = frame_end;
      if (frame_end) begin
         restart_scan();
      end else if (row_end) begin
         row_pos = row_pos + 8'd1;
         reverse_dir = !reverse_dir;
         col_pos = reverse_dir ? COL_BITS'(w - 1) : '0;
      end else begin
         col_pos = reverse_dir ? col - COL_BITS'(1) : col + COL_BITS'(1);
      end
   endtask

   // request driver
   always @(negedge clock) begin : driver
      pixel_req_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_pixels.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_req = pending_pixels.pop_front();
            req_valid       <= 1'b1;
            req_pixel_value <= next_req.pixel;
            req_frame_start <= next_req.frame_start;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // response monitor and request tracking
   always @(posedge clock) begin : monitor
      bin_result_type want;
      bin_result_type seen;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = '{binary_pixel: rsp_binary_pixel, column_index: rsp_column_index,
                     frame_last: rsp_frame_last};
            results_checked++;
            if (seen.frame_last) begin
               frames_closed++;
            end
            if (predicted_pixels.size() == 0) begin
               $error("response with no pending request: binary_pixel %0d column_index %0d",
                      seen.binary_pixel, seen.column_index);
               mismatch_count++;
            end else begin
               want = predicted_pixels.pop_front();
               if (seen.binary_pixel !== want.binary_pixel) begin
                  $error("binary_pixel: expected %0d, got %0d",
                         want.binary_pixel, seen.binary_pixel);
                  mismatch_count++;
               end
               if (seen.column_index !== want.column_index) begin
                  $error("column_index: expected %0d, got %0d",
                         want.column_index, seen.column_index);
                  mismatch_count++;
               end
               if (seen.frame_last !== want.frame_last) begin
                  $error("frame_last: expected %0d, got %0d",
                         want.frame_last, seen.frame_last);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            binarize_pixel(req_pixel_value, req_frame_start, want);
            predicted_pixels.push_back(want);
            pixels_accepted++;
         end
         req_taken <= req_valid && req_ready;
      end
   end

   task automatic csr_cycle(input logic wr, input logic [2:0] idx,
                            input logic [DATA_BITS-1:0] wdata,
                            output logic [DATA_BITS-1:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_read_check(input logic [2:0] idx);
      logic [DATA_BITS-1:0] rd;
      logic [DATA_BITS-1:0] want;
      string                name;
      case (idx)
         REG_IMAGE_WIDTH: begin
            want = DATA_BITS'(cfg_shadow.image_width);
            name = "image_width";
         end
         REG_IMAGE_HEIGHT: begin
            want = DATA_BITS'(cfg_shadow.image_height);
            name = "image_height";
         end
         REG_DECAY_MULTIPLIER: begin
            want = DATA_BITS'(cfg_shadow.decay_multiplier);
            name = "decay_multiplier";
         end
         REG_THRESHOLD_FACTOR: begin
            want = DATA_BITS'(cfg_shadow.threshold_factor);
            name = "threshold_factor";
         end
         default: begin
            want = DATA_BITS'(cfg_shadow.initial_sum);
            name = "initial_sum";
         end
      endcase
      csr_cycle(1'b0, idx, '0, rd);
      if (rd !== want) begin
         $error("%s: expected %0h, got %0h", name, want, rd);
         mismatch_count++;
      end
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [DATA_BITS-1:0] value);
      logic [DATA_BITS-1:0] unused;
      csr_cycle(1'b1, idx, value, unused);
      case (idx)
         REG_IMAGE_WIDTH:      cfg_shadow.image_width      = value[DIM_BITS-1:0];
         REG_IMAGE_HEIGHT:     cfg_shadow.image_height     = value[DIM_BITS-1:0];
         REG_DECAY_MULTIPLIER: cfg_shadow.decay_multiplier = value[COEF_BITS-1:0];
         REG_THRESHOLD_FACTOR: cfg_shadow.threshold_factor = value[COEF_BITS-1:0];
         REG_INITIAL_SUM:      cfg_shadow.initial_sum      = value[SUM_BITS-1:0];
         default: ;
      endcase
      csr_read_check(idx);
   endtask

   task automatic apply_settings(input int w, input int h, input int decay,
                                 input int factor, input int init);
      csr_write(REG_IMAGE_WIDTH, w);
      csr_write(REG_IMAGE_HEIGHT, h);
      csr_write(REG_DECAY_MULTIPLIER, decay);
      csr_write(REG_THRESHOLD_FACTOR, factor);
      csr_write(REG_INITIAL_SUM, init);
      settings_applied++;
   endtask

   task automatic push_pixel(input int pixel, input logic fs);
      pending_pixels.push_back('{pixel: pixel[PIX_BITS-1:0], frame_start: fs});
   endtask

   // image-like content: a drifting level with noise, some uniform samples,
   // frame starts mostly on frame boundaries
   task automatic queue_scan(input int count, input logic first_fs);
      int   frame_len;
      int   level;
      int   noise;
      int   v;
      logic fs;
      frame_len = dim_limit(cfg_shadow.image_width, MAX_WIDTH) *
                  dim_limit(cfg_shadow.image_height, MAX_HEIGHT);
      level = $urandom_range(0, 255);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 15) == 0) begin
            level = $urandom_range(0, 255);
         end
         if ($urandom_range(0, 3) == 0) begin
            v = $urandom_range(0, 255);
         end else begin
            noise = $urandom_range(0, 48);
            v = level + noise - 24;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
         end
         if (k == 0) begin
            fs = first_fs;
         end else if (k % frame_len == 0) begin
            fs = ($urandom_range(0, 1) == 1);
         end else begin
            fs = ($urandom_range(0, 99) == 0);
         end
         push_pixel(v, fs);
      end
   endtask

   task automatic wait_idle();
      while (pending_pixels.size() != 0 || req_valid || predicted_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (6) @(posedge clock);
   endtask

   initial begin : stimulus
      int w;
      int h;
      int decay;
      int factor;
      int init;
      int scale;
      int pct;
      int count;
      cfg_shadow = '{image_width: RESET_WIDTH, image_height: RESET_HEIGHT,
                     decay_multiplier: RESET_DECAY, threshold_factor: RESET_FACTOR,
                     initial_sum: RESET_INIT};
      for (int i = 0; i < MAX_WIDTH; i++) begin
         line_store[i] = '0;
      end
      restart_scan();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register defaults, then a few pixels at the reset geometry
      csr_read_check(REG_IMAGE_WIDTH);
      csr_read_check(REG_IMAGE_HEIGHT);
      csr_read_check(REG_DECAY_MULTIPLIER);
      csr_read_check(REG_THRESHOLD_FACTOR);
      csr_read_check(REG_INITIAL_SUM);
      queue_scan(4, 1'b0);
      wait_idle();

      // one full-width row fills every line entry before any geometry games
      apply_settings(MAX_WIDTH, 1, 490, 18, 2921);
      queue_scan(MAX_WIDTH, 1'b1);
      wait_idle();

      // zero geometry acts as one pixel per frame
      apply_settings(0, 0, 512, 512, 0);
      push_pixel(0, 1'b1);
      push_pixel(255, 1'b0);
      push_pixel(8'h80, 1'b0);
      wait_idle();

      // oversized geometry, maximum coefficients, saturating sum
      apply_settings(511, 511, 1023, 1023, 65535);
      push_pixel(255, 1'b1);
      push_pixel(255, 1'b0);
      push_pixel(0, 1'b0);
      push_pixel(8'haa, 1'b0);
      wait_idle();

      // zero decay and zero factor: every pixel is bright
      apply_settings(3, 3, 0, 0, 0);
      push_pixel(0, 1'b1);
      push_pixel(1, 1'b0);
      push_pixel(8'h55, 1'b0);
      wait_idle();

      // serpentine turn, mid-frame restart, then geometry shrunk mid-frame
      apply_settings(4, 4, 256, 300, 1000);
      push_pixel(10, 1'b1);
      push_pixel(200, 1'b0);
      push_pixel(30, 1'b0);
      push_pixel(250, 1'b0);
      push_pixel(5, 1'b0);
      push_pixel(128, 1'b1);
      push_pixel(64, 1'b0);
      wait_idle();
      apply_settings(2, 2, 480, 40, 3000);
      push_pixel(90, 1'b0);
      push_pixel(180, 1'b0);
      push_pixel(0, 1'b0);
      push_pixel(255, 1'b0);
      push_pixel(77, 1'b0);
      wait_idle();

      for (int mode = 0; mode < 4; mode++) begin
         case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
         endcase
         for (int s = 0; s < 8; s++) begin
            pct = $urandom_range(0, 9);
            if (pct == 0) begin
               w = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1) * MAX_WIDTH
                                               : $urandom_range(257, 511);
            end else begin
               w = $urandom_range(1, 12);
            end
            pct = $urandom_range(0, 9);
            if (pct == 0) begin
               h = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1) * MAX_HEIGHT
                                               : $urandom_range(257, 511);
            end else begin
               h = $urandom_range(1, 6);
            end
            if ($urandom_range(0, 1) == 0) begin
               // coefficients as software derives them from window and percent
               scale  = $urandom_range(2, 64);
               pct    = $urandom_range(0, 40);
               decay  = 512 - 512 / scale;
               factor = 512 * (100 - pct) / (100 * scale);
               init   = 127 * scale;
            end else begin
               decay  = $urandom_range(0, 1023);
               factor = $urandom_range(0, 1023);
               init   = $urandom_range(0, 65535);
            end
            apply_settings(w, h, decay, factor, init);
            count = $urandom_range(22, 54);
            if (mode == 3 && s == 4) begin
               // sender holds off until the pipeline has emptied
               queue_scan(count / 2, 1'b1);
               wait_idle();
               queue_scan(count - count / 2, 1'b0);
            end else begin
               queue_scan(count, $urandom_range(0, 4) != 0);
            end
            wait_idle();
         end
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      wait_idle();
      $display("covered %0d pixels and %0d responses over %0d register settings,",
               pixels_accepted, results_checked, settings_applied);
      $display("%0d frames closed under four idling patterns", frames_closed);
      if (mismatch_count == 0 && predicted_pixels.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/amab_pkg.sv
rtl/core/amab_ram.sv
rtl/core/amab_csr.sv
rtl/core/adaptive_moving_average_binarizer.sv
tb/tb_adaptive_moving_average_binarizer.sv
